[rtl/antenna_gain_from_direction_defines.svh]
// Assertion macros shared by the antenna gain RTL.
`ifndef ANTENNA_GAIN_FROM_DIRECTION_DEFINES_SVH
`define ANTENNA_GAIN_FROM_DIRECTION_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AGFD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("agfd: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define AGFD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("agfd: next-cycle check failed");

`endif

[rtl/agfd_pkg.sv]
// Types and constants of the antenna gain pipeline.
package agfd_pkg;

  // Fixed-point constants, angles in Q6.30
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;
  localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
  localparam logic signed [16:0] OFF_GAIN    = -17'sd51200;
  localparam logic signed [16:0] GAIN_LOW    = -17'sd65536;

  localparam int ATAN_LEN   = 24;
  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS  = 31;

  localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128
  };

  // Register indexes of the configuration port
  typedef enum logic [1:0] {
    REG_MAX_GAIN    = 2'd0,
    REG_BEAMWIDTH   = 2'd1,
    REG_ORIENT_AZ   = 2'd2,
    REG_ORIENT_INC  = 2'd3
  } reg_idx_t;

  // Rotation cell request: sine/cosine of one angle
  typedef struct packed {
    logic               vld;
    logic               neg;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
  } rot_t;

  // Square root digit request
  typedef struct packed {
    logic               vld;
    logic               off;
    logic signed [31:0] d;
    logic [60:0]        n;
    logic [61:0]        r;
  } sqrt_t;

  // Vectoring cell request: arctangent of (x, y)
  typedef struct packed {
    logic               vld;
    logic               off;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
  } vec_t;

  // Division step request: remainder and dividend/quotient shift word
  typedef struct packed {
    logic        vld;
    logic        off;
    logic [16:0] rem;
    logic [30:0] dq;
  } div_t;

endpackage

[rtl/agfd_rot_cell.sv]
// One rotation CORDIC stage of the sine/cosine chain.
module agfd_rot_cell #(
  parameter int STAGE = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  agfd_pkg::rot_t  cell_i,
  output agfd_pkg::rot_t  cell_o
);

  agfd_pkg::rot_t cell_r, cell_nxt;
  logic signed [32:0] atan_s;

  assign atan_s = $signed({1'b0, agfd_pkg::ATAN_Q30[STAGE]});

  // Rotate toward zero residual angle
  always_comb begin
    cell_nxt = cell_i;
    if (!cell_i.z[32]) begin
      cell_nxt.x = cell_i.x - (cell_i.y >>> STAGE);
      cell_nxt.y = cell_i.y + (cell_i.x >>> STAGE);
      cell_nxt.z = cell_i.z - atan_s;
    end else begin
      cell_nxt.x = cell_i.x + (cell_i.y >>> STAGE);
      cell_nxt.y = cell_i.y - (cell_i.x >>> STAGE);
      cell_nxt.z = cell_i.z + atan_s;
    end
  end

  // Advance on enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule

[rtl/agfd_sqrt_cell.sv]
// One digit step of the pipelined integer square root.
module agfd_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  agfd_pkg::sqrt_t  cell_i,
  output agfd_pkg::sqrt_t  cell_o
);

  localparam logic [61:0] BIT_W = 62'd1 << (60 - 2 * STEP);

  agfd_pkg::sqrt_t cell_r, cell_nxt;
  logic [61:0] trial;

  assign trial = cell_i.r + BIT_W;

  // Accept the digit when the remainder covers the trial value
  always_comb begin
    cell_nxt = cell_i;
    if ({1'b0, cell_i.n} >= trial) begin
      cell_nxt.n = cell_i.n - trial[60:0];
      cell_nxt.r = (cell_i.r >> 1) + BIT_W;
    end else begin
      cell_nxt.r = cell_i.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule

[rtl/agfd_vec_cell.sv]
// One vectoring CORDIC stage of the arccos chain.
module agfd_vec_cell #(
  parameter int STAGE = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  agfd_pkg::vec_t  cell_i,
  output agfd_pkg::vec_t  cell_o
);

  agfd_pkg::vec_t cell_r, cell_nxt;
  logic signed [32:0] atan_s;

  assign atan_s = $signed({1'b0, agfd_pkg::ATAN_Q30[STAGE]});

  // Rotate toward the x axis, collect the angle
  always_comb begin
    cell_nxt = cell_i;
    if (!cell_i.y[33]) begin
      cell_nxt.x = cell_i.x + (cell_i.y >>> STAGE);
      cell_nxt.y = cell_i.y - (cell_i.x >>> STAGE);
      cell_nxt.z = cell_i.z + atan_s;
    end else begin
      cell_nxt.x = cell_i.x - (cell_i.y >>> STAGE);
      cell_nxt.y = cell_i.y + (cell_i.x >>> STAGE);
      cell_nxt.z = cell_i.z - atan_s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule

[rtl/agfd_div_cell.sv]
// One restoring division step: one quotient bit per cell.
module agfd_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic [16:0]     divisor,
  input  agfd_pkg::div_t  cell_i,
  output agfd_pkg::div_t  cell_o
);

  agfd_pkg::div_t cell_r, cell_nxt;
  logic [17:0] part;
  logic        ge;

  assign part = {cell_i.rem, cell_i.dq[30]};
  assign ge   = part >= {1'b0, divisor};

  // Subtract when the partial remainder covers the divisor
  always_comb begin
    cell_nxt     = cell_i;
    cell_nxt.rem = ge ? 17'(part - {1'b0, divisor}) : part[16:0];
    cell_nxt.dq  = {cell_i.dq[29:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule

[rtl/antenna_gain_from_direction.sv]
// Antenna gain from direction: CORDIC sin/cos, dot product, sqrt, arccos, divide, square.
// Throughput: one request per cycle while out_stall does not hold the pipeline; the rotation,
// root, vectoring and divider cell chains each hand one request to the next cell every cycle.
// A waiting result under out_stall holds the whole pipeline in place.
// Synchronous active-low reset clears all valid bits and loads register reset values.
module antenna_gain_from_direction #(
  parameter int CORDIC_STAGES = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_dir_azimuth,
  input  logic [14:0]        in_dir_inclination,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] out_gain_db,
  output logic               out_off_beam,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

`include "antenna_gain_from_direction_defines.svh"

  localparam int NS = CORDIC_STAGES;

  // ---------------- configuration port ----------------
  logic signed [15:0] max_gain_r;
  logic [14:0]        beamwidth_r;
  logic signed [14:0] orient_azimuth_r;
  logic [14:0]        orient_inclination_r;
  agfd_pkg::reg_idx_t reg_idx;
  logic               cfg_wr;

  assign reg_idx = agfd_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_gain_r           <= '0;
      beamwidth_r          <= 15'd8579;
      orient_azimuth_r     <= '0;
      orient_inclination_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        agfd_pkg::REG_MAX_GAIN:   max_gain_r           <= pwdata[15:0];
        agfd_pkg::REG_BEAMWIDTH:  beamwidth_r          <= pwdata[14:0];
        agfd_pkg::REG_ORIENT_AZ:  orient_azimuth_r     <= pwdata[14:0];
        agfd_pkg::REG_ORIENT_INC: orient_inclination_r <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_idx)
      agfd_pkg::REG_MAX_GAIN:   prdata = {16'd0, max_gain_r};
      agfd_pkg::REG_BEAMWIDTH:  prdata = {17'd0, beamwidth_r};
      agfd_pkg::REG_ORIENT_AZ:  prdata = {17'd0, orient_azimuth_r};
      agfd_pkg::REG_ORIENT_INC: prdata = {17'd0, orient_inclination_r};
      default:                  prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // ---------------- angle reduction ----------------
  function automatic agfd_pkg::rot_t rot_start(input logic signed [15:0] ang);
    logic signed [35:0] z;
    agfd_pkg::rot_t     s;
    z     = {{3{ang[15]}}, ang, 17'd0};
    s.vld = 1'b0;
    s.neg = 1'b0;
    if (z > agfd_pkg::PI_Q30) begin
      z = z - agfd_pkg::TWO_PI_Q30;
    end else if (z < -agfd_pkg::PI_Q30) begin
      z = z + agfd_pkg::TWO_PI_Q30;
    end
    if (z > agfd_pkg::HALF_PI_Q30) begin
      z     = z - agfd_pkg::PI_Q30;
      s.neg = 1'b1;
    end else if (z < -agfd_pkg::HALF_PI_Q30) begin
      z     = z + agfd_pkg::PI_Q30;
      s.neg = 1'b1;
    end
    s.x = agfd_pkg::CORDIC_K;
    s.y = '0;
    s.z = z[32:0];
    return s;
  endfunction

  // Lanes: 0 pointing inclination, 1 pointing azimuth, 2 query inclination, 3 query azimuth
  logic signed [15:0] ang [4];
  agfd_pkg::rot_t     rot_c [4][NS+1];

  assign ang[0] = $signed({1'b0, orient_inclination_r});
  assign ang[1] = {orient_azimuth_r[14], orient_azimuth_r};
  assign ang[2] = $signed({1'b0, in_dir_inclination});
  assign ang[3] = in_dir_azimuth;

  genvar k, i;
  generate
    for (k = 0; k < 4; k++) begin : g_lane
      agfd_pkg::rot_t start_r, start_nxt;

      // Reduce and fold the angle into the CORDIC range
      always_comb begin
        start_nxt     = rot_start(ang[k]);
        start_nxt.vld = in_valid;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          start_r.vld <= 1'b0;
        end else if (adv) begin
          start_r <= start_nxt;
        end
      end

      assign rot_c[k][0] = start_r;

      for (i = 0; i < NS; i++) begin : g_rot
        agfd_rot_cell #(.STAGE(i)) u_cell (
          .clk    (clk),
          .rst_n  (rst_n),
          .en     (adv),
          .cell_i (rot_c[k][i]),
          .cell_o (rot_c[k][i+1])
        );
      end
    end
  endgenerate

  // ---------------- sign restore ----------------
  logic signed [31:0] sin_r [4];
  logic signed [31:0] cos_r [4];
  logic               neg_vld_r;

  generate
    for (k = 0; k < 4; k++) begin : g_neg
      logic signed [33:0] s_full, c_full;
      assign s_full = rot_c[k][NS].neg ? -rot_c[k][NS].y : rot_c[k][NS].y;
      assign c_full = rot_c[k][NS].neg ? -rot_c[k][NS].x : rot_c[k][NS].x;
      always_ff @(posedge clk) begin
        if (adv) begin
          sin_r[k] <= s_full[31:0];
          cos_r[k] <= c_full[31:0];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_vld_r <= 1'b0;
    end else if (adv) begin
      neg_vld_r <= rot_c[3][NS].vld;
    end
  end

  // ---------------- unit vectors ----------------
  logic signed [63:0] ox_r, oy_r, gx_r, gy_r;
  logic signed [31:0] oz_r, gz_r;
  logic               m1_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else if (adv) begin
      m1_vld_r <= neg_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ox_r <= sin_r[0] * cos_r[1];
      oy_r <= sin_r[0] * sin_r[1];
      oz_r <= cos_r[0];
      gx_r <= sin_r[2] * cos_r[3];
      gy_r <= sin_r[2] * sin_r[3];
      gz_r <= cos_r[2];
    end
  end

  // ---------------- dot product terms ----------------
  logic signed [63:0] ex_r, ey_r, ez_r;
  logic               m2_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else if (adv) begin
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ex_r <= $signed(ox_r[61:30]) * $signed(gx_r[61:30]);
      ey_r <= $signed(oy_r[61:30]) * $signed(gy_r[61:30]);
      ez_r <= oz_r * gz_r;
    end
  end

  // ---------------- dot product sum and clamp ----------------
  logic signed [35:0] dot_sum;
  logic signed [31:0] d_nxt;
  logic signed [31:0] d_r;
  logic               d_vld_r;

  assign dot_sum = {{2{ex_r[63]}}, ex_r[63:30]} + {{2{ey_r[63]}}, ey_r[63:30]}
                 + {{2{ez_r[63]}}, ez_r[63:30]};

  always_comb begin
    if (dot_sum > 36'sd1073741824) begin
      d_nxt = agfd_pkg::ONE_Q30;
    end else if (dot_sum < -36'sd1073741824) begin
      d_nxt = -agfd_pkg::ONE_Q30;
    end else begin
      d_nxt = dot_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (adv) begin
      d_vld_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r <= d_nxt;
    end
  end

  // ---------------- square of d ----------------
  logic signed [63:0] dd_r;
  logic signed [31:0] sq_d_r;
  logic               sq_off_r;
  logic               sq_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
    end else if (adv) begin
      sq_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dd_r     <= d_r * d_r;
      sq_d_r   <= d_r;
      sq_off_r <= d_r[31] || (d_r == '0);
    end
  end

  // ---------------- square root chain ----------------
  agfd_pkg::sqrt_t sq_c [agfd_pkg::SQRT_STEPS+1];

  always_comb begin
    sq_c[0].vld = sq_vld_r;
    sq_c[0].off = sq_off_r;
    sq_c[0].d   = sq_d_r;
    sq_c[0].n   = (61'd1 << 60) - dd_r[60:0];
    sq_c[0].r   = '0;
  end

  generate
    for (i = 0; i < agfd_pkg::SQRT_STEPS; i++) begin : g_sqrt
      agfd_sqrt_cell #(.STEP(i)) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .cell_i (sq_c[i]),
        .cell_o (sq_c[i+1])
      );
    end
  endgenerate

  // ---------------- arccos vectoring chain ----------------
  agfd_pkg::vec_t vec_c [NS+1];
  agfd_pkg::sqrt_t sq_last;

  assign sq_last = sq_c[agfd_pkg::SQRT_STEPS];

  always_comb begin
    vec_c[0].vld = sq_last.vld;
    vec_c[0].off = sq_last.off;
    vec_c[0].x   = {{2{sq_last.d[31]}}, sq_last.d};
    vec_c[0].y   = {3'd0, sq_last.r[30:0]};
    vec_c[0].z   = '0;
  end

  generate
    for (i = 0; i < NS; i++) begin : g_vec
      agfd_vec_cell #(.STAGE(i)) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .cell_i (vec_c[i]),
        .cell_o (vec_c[i+1])
      );
    end
  endgenerate

  // ---------------- angle clamp and beam check ----------------
  agfd_pkg::div_t dv_c [agfd_pkg::DIV_STEPS+1];
  agfd_pkg::div_t dv_a_r, dv_a_nxt;
  logic signed [32:0] z_end;
  logic [32:0]        z_clamp;

  assign z_end   = vec_c[NS].z;
  assign z_clamp = z_end[32] ? 33'd0 : z_end;

  always_comb begin
    dv_a_nxt.vld = vec_c[NS].vld;
    dv_a_nxt.off = vec_c[NS].off || ($signed({3'd0, z_clamp}) >= agfd_pkg::HALF_PI_Q30);
    dv_a_nxt.rem = '0;
    dv_a_nxt.dq  = z_clamp[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_a_r.vld <= 1'b0;
    end else if (adv) begin
      dv_a_r <= dv_a_nxt;
    end
  end

  assign dv_c[0] = dv_a_r;

  // ---------------- divide by twice the beamwidth ----------------
  logic [14:0] bw_eff;
  logic [16:0] divisor;

  assign bw_eff  = (beamwidth_r == '0) ? 15'd1 : beamwidth_r;
  assign divisor = {1'b0, bw_eff, 1'b0};

  generate
    for (i = 0; i < agfd_pkg::DIV_STEPS; i++) begin : g_div
      agfd_div_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .divisor (divisor),
        .cell_i  (dv_c[i]),
        .cell_o  (dv_c[i+1])
      );
    end
  endgenerate

  // ---------------- ratio square ----------------
  agfd_pkg::div_t dv_last;
  logic [39:0]    rr_r;
  logic           rr_huge_r;
  logic           rr_off_r;
  logic           rr_vld_r;

  assign dv_last = dv_c[agfd_pkg::DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rr_vld_r <= 1'b0;
    end else if (adv) begin
      rr_vld_r <= dv_last.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rr_r      <= dv_last.dq[19:0] * dv_last.dq[19:0];
      rr_huge_r <= |dv_last.dq[30:20];
      rr_off_r  <= dv_last.off;
    end
  end

  // ---------------- penalty, 12 * r^2 rounded ----------------
  logic [43:0] pen_full;
  logic [19:0] pen_r;
  logic        pen_huge_r;
  logic        pen_off_r;
  logic        pen_vld_r;

  assign pen_full = ({4'd0, rr_r} << 3) + ({4'd0, rr_r} << 2) + (44'd1 << 23);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_vld_r <= 1'b0;
    end else if (adv) begin
      pen_vld_r <= rr_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pen_r      <= pen_full[43:24];
      pen_huge_r <= rr_huge_r;
      pen_off_r  <= rr_off_r;
    end
  end

  // ---------------- gain and output register ----------------
  logic signed [20:0] gain_full;
  logic signed [16:0] gain_nxt;
  logic signed [16:0] gain_r;
  logic               off_r;

  assign gain_full = {{5{max_gain_r[15]}}, max_gain_r} - $signed({1'b0, pen_r});

  always_comb begin
    if (pen_off_r) begin
      gain_nxt = agfd_pkg::OFF_GAIN;
    end else if (pen_huge_r || (gain_full < -21'sd65536)) begin
      gain_nxt = agfd_pkg::GAIN_LOW;
    end else begin
      gain_nxt = gain_full[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= pen_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gain_r <= gain_nxt;
      off_r  <= pen_off_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_gain_db  = gain_r;
  assign out_off_beam = off_r;

  // ---------------- assertions ----------------
  `AGFD_ASSERT_NXT(a_accept_enters, in_valid && !in_stall, g_lane[0].start_r.vld)
  `AGFD_ASSERT_IMP(a_dot_clamped, d_vld_r,
    (d_r <= agfd_pkg::ONE_Q30) && (d_r >= -agfd_pkg::ONE_Q30))
  `AGFD_ASSERT_IMP(a_off_gain, out_valid_r && off_r, gain_r == agfd_pkg::OFF_GAIN)
  `AGFD_ASSERT_IMP(a_gain_below_peak, out_valid_r && !off_r,
    ($signed(gain_r) <= $signed({max_gain_r[15], max_gain_r})) &&
    ($signed(gain_r) >= agfd_pkg::GAIN_LOW))

endmodule
